// File: rtl/lcmd_pkg.sv
// Shared types, codes and keyword tables for the line command keyword parser.
`default_nettype none

package lcmd_pkg;

  // Line length limit: at most MAX_LINE-1 bytes of a line are counted
  localparam int MAX_LINE_DEFAULT = 32;

  // Leading bytes of a line kept for keyword matching
  localparam int KEEP_BYTES = 5;
  localparam int KEY_COUNT  = 6;
  localparam int LEN_W      = $clog2(KEEP_BYTES + 1);

  // Request kinds
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Line terminators
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [2:0] {
    CODE_NONE  = 3'd0,
    CODE_START = 3'd1,
    CODE_STOP  = 3'd2,
    CODE_FWD   = 3'd3,
    CODE_BWD   = 3'd4,
    CODE_LEFT  = 3'd5,
    CODE_RIGHT = 3'd6
  } code_t;

  typedef logic [KEEP_BYTES-1:0][7:0] prefix_t;

  // Keyword text, padded with zeros past the keyword length
  localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEEP_BYTES] = '{
    '{8'h53, 8'h54, 8'h41, 8'h52, 8'h54},  // START
    '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00},  // STOP
    '{8'h46, 8'h57, 8'h44, 8'h00, 8'h00},  // FWD
    '{8'h42, 8'h57, 8'h44, 8'h00, 8'h00},  // BWD
    '{8'h4C, 8'h45, 8'h46, 8'h54, 8'h00},  // LEFT
    '{8'h52, 8'h49, 8'h47, 8'h48, 8'h54}   // RIGHT
  };

  localparam logic [LEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
    LEN_W'(5), LEN_W'(4), LEN_W'(3), LEN_W'(3), LEN_W'(4), LEN_W'(5)
  };

  // Prefix match against all keywords in parallel; the earliest keyword wins.
  // len is the line length, saturated at KEEP_BYTES.
  function automatic code_t match_line(input prefix_t bytes, input logic [LEN_W-1:0] len);
    code_t code;
    logic  ok;
    code = CODE_NONE;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      ok = (len >= KEY_LEN[k]);
      for (int i = 0; i < KEEP_BYTES; i++) begin
        if ((i < int'(KEY_LEN[k])) && (bytes[i] != KEY_TEXT[k][i])) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        code = code_t'(3'(k + 1));
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/line_command_keyword_parser.sv
// Top level of the line command keyword parser: line buffer, matcher and result register.
//
// Usage:
//   Input channel (in_valid/in_ready, op, rx_byte) carries one request per
//   cycle while in_ready is high: op = OP_BYTE delivers a received character,
//   op = OP_FETCH reads and clears the pending command. CR or LF ends a line; a
//   non-empty line is prefix-matched against START, STOP, FWD, BWD, LEFT, RIGHT.
//   Output channel (out_valid/out_ready, cmd_flag, command_code) returns
//   exactly one result per request: the ready flag after the request, and for
//   a fetch the returned code (CODE_NONE when nothing was pending).
//   The result is registered: it is valid in the cycle after the request is accepted.
//   Throughput: one request per cycle when not stalled; the keyword compare is a
//   single combinational pass between the line state and the result register.
//   A new request is taken while the previous result is still held, as long
//   as the result register is empty or being drained in the same cycle.
//   Stall: while out_valid is high and out_ready low, the result holds and
//   in_ready drops.
//   Reset (rst, synchronous): clears the line count, stored code, ready flag
//   and the result register; the block accepts requests the next cycle.
`default_nettype none

module line_command_keyword_parser #(
  parameter int MAX_LINE = lcmd_pkg::MAX_LINE_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       op,
  input  wire logic [7:0] rx_byte,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       cmd_flag,
  output      logic [2:0] command_code
);

  localparam int CNT_W = $clog2(MAX_LINE);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LINE - 1);
  localparam logic [CNT_W-1:0] CNT_KEEP  = CNT_W'(lcmd_pkg::KEEP_BYTES);

  // Line state
  logic [CNT_W-1:0]        fill_count, fill_count_next;
  lcmd_pkg::prefix_t       prefix_bytes;
  lcmd_pkg::code_t         stored_code, stored_code_next;
  logic                    ready_flag, ready_flag_next;

  logic                    accept;
  logic                    is_term;
  logic [lcmd_pkg::LEN_W-1:0] line_len;
  lcmd_pkg::code_t         line_code;
  lcmd_pkg::code_t         code_out;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_term  = (rx_byte == lcmd_pkg::CHAR_LF) || (rx_byte == lcmd_pkg::CHAR_CR);

  // Line length seen by the matcher, saturated at the kept prefix
  assign line_len  = (fill_count >= CNT_KEEP) ? lcmd_pkg::LEN_W'(lcmd_pkg::KEEP_BYTES)
                                              : lcmd_pkg::LEN_W'(fill_count);
  assign line_code = lcmd_pkg::match_line(prefix_bytes, line_len);

  // Next state and result for the current request
  always_comb begin
    fill_count_next  = fill_count;
    stored_code_next = stored_code;
    ready_flag_next  = ready_flag;
    code_out         = lcmd_pkg::CODE_NONE;
    if (op == lcmd_pkg::OP_FETCH) begin
      code_out        = ready_flag ? stored_code : lcmd_pkg::CODE_NONE;
      ready_flag_next = 1'b0;
    end else if (is_term) begin
      if (fill_count != '0) begin
        stored_code_next = line_code;
        fill_count_next  = '0;
        if (line_code != lcmd_pkg::CODE_NONE) begin
          ready_flag_next = 1'b1;
        end
      end
    end else if (fill_count < CNT_LIMIT) begin
      fill_count_next = fill_count + CNT_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      stored_code <= lcmd_pkg::CODE_NONE;
      ready_flag  <= 1'b0;
    end else if (accept) begin
      fill_count  <= fill_count_next;
      stored_code <= stored_code_next;
      ready_flag  <= ready_flag_next;
    end
  end

  // Prefix capture: only the first bytes of a line are kept
  always_ff @(posedge clk) begin
    if (accept && (op == lcmd_pkg::OP_BYTE) && !is_term && (fill_count < CNT_KEEP)) begin
      prefix_bytes[fill_count[lcmd_pkg::LEN_W-1:0]] <= rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_flag     <= ready_flag_next;
      command_code <= code_out;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lcmd_checker.sv
// Port-level checker for the line command keyword parser, with its bind.
`default_nettype none

module lcmd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       op,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       cmd_flag,
  input wire logic [2:0] command_code
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cmd_flag) && $stable(command_code))
    else $error("stalled result changed");

  // A fetch request always leaves the ready flag clear in its result
  a_fetch_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == lcmd_pkg::OP_FETCH) |=> out_valid && !cmd_flag)
    else $error("fetch result shows ready flag set");

  // A received-byte request never reports a code
  a_byte_no_code: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == lcmd_pkg::OP_BYTE) |=>
      out_valid && (command_code == lcmd_pkg::CODE_NONE))
    else $error("byte request returned a code");

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind line_command_keyword_parser lcmd_checker u_lcmd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .op           (op),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cmd_flag     (cmd_flag),
  .command_code (command_code)
);

`default_nettype wire

// File: sim/line_command_keyword_parser_test.sv
// Self-checking testbench for the line command keyword parser.
`default_nettype none

module line_command_keyword_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT   = lcmd_pkg::MAX_LINE_DEFAULT;
  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 80;

  // One expected reply per request
  typedef struct packed {
    logic            rdy;
    lcmd_pkg::code_t code;
  } cmd_reply_t;

  // Tracks the line buffer and pending command, and checks replies in order
  class keyword_line_tracker;
    logic [7:0]      line_head [lcmd_pkg::KEEP_BYTES];
    int unsigned     line_len;
    int unsigned     max_len;
    lcmd_pkg::code_t parsed_code;
    bit              cmd_pending;
    cmd_reply_t      pending_replies [$];
    int unsigned     mismatches;
    string           keywords [lcmd_pkg::KEY_COUNT];
    lcmd_pkg::code_t keyword_codes [lcmd_pkg::KEY_COUNT];

    function new(int unsigned line_limit);
      keywords      = '{"START", "STOP", "FWD", "BWD", "LEFT", "RIGHT"};
      keyword_codes = '{lcmd_pkg::CODE_START, lcmd_pkg::CODE_STOP, lcmd_pkg::CODE_FWD,
                        lcmd_pkg::CODE_BWD, lcmd_pkg::CODE_LEFT, lcmd_pkg::CODE_RIGHT};
      max_len       = line_limit - 1;
      line_len      = 0;
      parsed_code   = lcmd_pkg::CODE_NONE;
      cmd_pending   = 1'b0;
      mismatches    = 0;
      foreach (line_head[i]) line_head[i] = 8'h00;
    endfunction

    // First keyword that is a prefix of the current line, in table order
    function lcmd_pkg::code_t classify_line();
      bit hit;
      for (int k = 0; k < lcmd_pkg::KEY_COUNT; k++) begin
        hit = (line_len >= keywords[k].len());
        for (int i = 0; hit && i < keywords[k].len(); i++) begin
          if (line_head[i] != keywords[k][i]) hit = 1'b0;
        end
        if (hit) return keyword_codes[k];
      end
      return lcmd_pkg::CODE_NONE;
    endfunction

    function void note_request(logic kind, logic [7:0] ch);
      cmd_reply_t reply;
      reply.code = lcmd_pkg::CODE_NONE;
      if (kind == lcmd_pkg::OP_FETCH) begin
        if (cmd_pending) reply.code = parsed_code;
        cmd_pending = 1'b0;
      end else if (ch == lcmd_pkg::CHAR_LF || ch == lcmd_pkg::CHAR_CR) begin
        // empty line changes nothing
        if (line_len != 0) begin
          parsed_code = classify_line();
          line_len    = 0;
          if (parsed_code != lcmd_pkg::CODE_NONE) cmd_pending = 1'b1;
        end
      end else if (line_len < max_len) begin
        if (line_len < lcmd_pkg::KEEP_BYTES) line_head[line_len] = ch;
        line_len++;
      end
      reply.rdy = cmd_pending;
      pending_replies.push_back(reply);
    endfunction

    function void check_result(logic rdy, logic [2:0] code);
      cmd_reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing expected: cmd_flag=%0b command_code=%0d",
                 $time, rdy, code);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (rdy !== want.rdy) begin
        $display("%0t: cmd_flag expected %0b actual %0b", $time, want.rdy, rdy);
        mismatches++;
      end
      if (code !== want.code) begin
        $display("%0t: command_code expected %0d actual %0d", $time, want.code, code);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = lcmd_pkg::OP_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       cmd_flag;
  logic [2:0] command_code;

  keyword_line_tracker tracker = new(LINE_LIMIT);

  int unsigned sent_count    = 0;
  int unsigned cycle_count   = 0;
  int          send_idle_pct = 35;
  int          sink_idle_pct = 35;
  logic        sink_hold_req = 1'b0;
  bit          hold_done     = 1'b0;
  int          hold_left     = 0;

  line_command_keyword_parser #(
    .MAX_LINE(LINE_LIMIT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd_flag     (cmd_flag),
    .command_code (command_code)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (sink_hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_request(op, rx_byte);
      if (out_valid && out_ready) tracker.check_result(cmd_flag, command_code);
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_request(input logic kind, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    rx_byte  <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(lcmd_pkg::OP_BYTE, s[i]);
  endtask

  task automatic send_terminator();
    send_request(lcmd_pkg::OP_BYTE, $urandom_range(1) ? lcmd_pkg::CHAR_CR : lcmd_pkg::CHAR_LF);
  endtask

  task automatic send_fetch();
    send_request(lcmd_pkg::OP_FETCH, 8'($urandom));
  endtask

  // Random character that does not end a line
  function automatic logic [7:0] any_char();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == lcmd_pkg::CHAR_LF || b == lcmd_pkg::CHAR_CR) b = 8'($urandom);
    return b;
  endfunction

  initial begin
    int         pick;
    int         k;
    int         n;
    int         p;
    int         extra;
    int unsigned stop_at;
    string      kw;
    logic [7:0] ch;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fetch with nothing pending, empty line, keyword hits,
    // short unknown line that keeps the flag, zero byte inside a keyword
    send_fetch();
    send_request(lcmd_pkg::OP_BYTE, lcmd_pkg::CHAR_LF);
    send_text("FWD");
    send_request(lcmd_pkg::OP_BYTE, lcmd_pkg::CHAR_LF);
    send_fetch();
    send_text("STOP");
    send_request(lcmd_pkg::OP_BYTE, lcmd_pkg::CHAR_CR);
    send_text("STAR");
    send_request(lcmd_pkg::OP_BYTE, lcmd_pkg::CHAR_LF);
    send_fetch();
    send_text("L");
    send_request(lcmd_pkg::OP_BYTE, 8'h00);
    send_text("FT");
    send_request(lcmd_pkg::OP_BYTE, lcmd_pkg::CHAR_CR);
    send_fetch();

    // Random: mostly keyword-shaped lines, some noise and fetches
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      if (sent_count >= 600 && sent_count < 900) begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        send_idle_pct = 35;
        sink_idle_pct = 35;
      end
      if (sent_count >= 300) sink_hold_req <= 1'b1;

      pick = $urandom_range(99);
      k    = $urandom_range(lcmd_pkg::KEY_COUNT - 1);
      kw   = tracker.keywords[k];
      if (pick < 40) begin
        // full keyword, optional tail, now and then past the line limit
        send_text(kw);
        extra = ($urandom_range(19) == 0) ? $urandom_range(26, 40) : $urandom_range(0, 4);
        repeat (extra) send_request(lcmd_pkg::OP_BYTE, any_char());
        send_terminator();
      end else if (pick < 55) begin
        // keyword cut short
        n = $urandom_range(1, kw.len() - 1);
        send_text(kw.substr(0, n - 1));
        send_terminator();
      end else if (pick < 65) begin
        // keyword with one byte replaced
        p = $urandom_range(kw.len() - 1);
        for (int i = 0; i < kw.len(); i++) begin
          ch = $urandom_range(1) ? 8'h00 : any_char();
          send_request(lcmd_pkg::OP_BYTE, (i == p) ? ch : kw[i]);
        end
        send_terminator();
      end else if (pick < 75) begin
        n = $urandom_range(1, 8);
        repeat (n) send_request(lcmd_pkg::OP_BYTE, any_char());
        send_terminator();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 2)) send_fetch();
      end else begin
        send_terminator();
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch a few more cycles for stray results
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
